// File: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg - shared types and constants for the minimum separation push-out
// Beat layouts, queue entry, pipeline sidecar and saturation helper.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int SEP_W     = 18;
    localparam int SQ_STAGES = 18;   // one root bit per stage
    localparam int DV_STAGES = 19;   // one quotient bit per stage

    // input beat
    typedef struct packed {
        logic signed [31:0] mover_x;
        logic signed [31:0] mover_y;
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
        logic               mover_alive;
    } msp_in_t;

    // result beat
    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic               pushed;
    } msp_out_t;

    // classified item as it sits in the queue
    typedef struct packed {
        logic               near;
        logic               sx;
        logic               sy;
        logic [SEP_W-1:0]   adx;
        logic [SEP_W-1:0]   ady;
        logic signed [31:0] mover_x;
        logic signed [31:0] mover_y;
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
    } msp_item_t;

    // item travelling alongside the arithmetic units
    typedef struct packed {
        logic      push;
        logic      zero;
        msp_item_t item;
    } msp_side_t;

    // saturate a 34-bit sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: design/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front - accept and classify
// Takes input beats, forms the deltas and flags pairs close enough to resolve.
// ----------------------------------------------------------------------------
module msp_front (
    input  logic               start,
    input  logic               full,
    input  msp_pkg::msp_in_t   item,
    output logic               busy,
    output logic               wr_en,
    output msp_pkg::msp_item_t wr_item
);

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        adx;
    logic [32:0]        ady;

    // exact deltas and their magnitudes
    assign dx  = 33'(item.mover_x) - 33'(item.anchor_x);
    assign dy  = 33'(item.mover_y) - 33'(item.anchor_y);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    // handshake: stall only when the queue is full
    assign busy  = full;
    assign wr_en = start && !full;

    // classification
    always_comb
    begin
        wr_item.near     = item.mover_alive && (adx < 33'h4_0000) && (ady < 33'h4_0000);
        wr_item.sx       = dx[32];
        wr_item.sy       = dy[32];
        wr_item.adx      = adx[msp_pkg::SEP_W-1:0];
        wr_item.ady      = ady[msp_pkg::SEP_W-1:0];
        wr_item.mover_x  = item.mover_x;
        wr_item.mover_y  = item.mover_y;
        wr_item.anchor_x = item.anchor_x;
        wr_item.anchor_y = item.anchor_y;
    end

endmodule

// File: design/msp_queue.sv
// ----------------------------------------------------------------------------
// msp_queue - two-entry queue between front and back
// Lets either side stall without losing a beat.
// ----------------------------------------------------------------------------
module msp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  msp_pkg::msp_item_t wr_item,
    input  logic               rd_en,
    output logic               full,
    output logic               empty,
    output msp_pkg::msp_item_t rd_item
);

    msp_pkg::msp_item_t mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem[rp_reg];

    // pointer and fill count
    always_comb
    begin
        wp_next  = wr_en ? ~wp_reg : wp_reg;
        rp_next  = do_rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(wr_en) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_item;
    end

endmodule

// File: design/msp_isqrt.sv
// ----------------------------------------------------------------------------
// msp_isqrt - pipelined integer square root
// Digit-by-digit restoring root of a 36-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module msp_isqrt (
    input  logic        clk,
    input  logic [35:0] rad,
    output logic [17:0] root
);

    localparam int N = msp_pkg::SQ_STAGES;

    logic [19:0] rem_reg  [N];
    logic [17:0] root_reg [N];
    logic [35:0] rad_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [19:0] in_rem;
        logic [17:0] in_root;
        logic [35:0] in_rad;
        logic [19:0] r;
        logic [19:0] trial;

        if (k == 0)
        begin : g_first
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_rad  = rad;
        end
        else
        begin : g_next
            assign in_rem  = rem_reg[k-1];
            assign in_root = root_reg[k-1];
            assign in_rad  = rad_reg[k-1];
        end

        // bring down two bits and try 4*root+1
        assign r     = {in_rem[17:0], in_rad[35:34]};
        assign trial = {in_root, 2'b01};

        always_ff @(posedge clk)
        begin
            if (r >= trial)
            begin
                rem_reg[k]  <= r - trial;
                root_reg[k] <= {in_root[16:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= r;
                root_reg[k] <= {in_root[16:0], 1'b0};
            end
            rad_reg[k] <= {in_rad[33:0], 2'b00};
        end
    end

    assign root = root_reg[N-1];

endmodule

// File: design/msp_div.sv
// ----------------------------------------------------------------------------
// msp_div - pipelined restoring divider
// 37-bit dividend over 18-bit divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module msp_div (
    input  logic        clk,
    input  logic [36:0] num,
    input  logic [17:0] den,
    output logic [18:0] quo
);

    localparam int N = msp_pkg::DV_STAGES;

    logic [17:0] rem_reg [N];
    logic [18:0] nb_reg  [N];
    logic [17:0] den_reg [N];
    logic [18:0] q_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [17:0] in_rem;
        logic [18:0] in_nb;
        logic [17:0] in_den;
        logic [18:0] in_q;
        logic [18:0] t;

        if (k == 0)
        begin : g_first
            assign in_rem = num[36:19];
            assign in_nb  = num[18:0];
            assign in_den = den;
            assign in_q   = '0;
        end
        else
        begin : g_next
            assign in_rem = rem_reg[k-1];
            assign in_nb  = nb_reg[k-1];
            assign in_den = den_reg[k-1];
            assign in_q   = q_reg[k-1];
        end

        // bring down one bit, subtract if it fits
        assign t = {in_rem, in_nb[18]};

        always_ff @(posedge clk)
        begin
            if (t >= {1'b0, in_den})
            begin
                rem_reg[k] <= 18'(t - {1'b0, in_den});
                q_reg[k]   <= {in_q[17:0], 1'b1};
            end
            else
            begin
                rem_reg[k] <= t[17:0];
                q_reg[k]   <= {in_q[17:0], 1'b0};
            end
            nb_reg[k]  <= {in_nb[17:0], 1'b0};
            den_reg[k] <= in_den;
        end
    end

    assign quo = q_reg[N-1];

endmodule

// File: design/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back - resolution pipeline
// Squares, compare, square root, scale, divide, add and saturate.
// ----------------------------------------------------------------------------
module msp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [17:0]        sep,
    input  logic [35:0]        sep2,
    input  logic               empty,
    input  msp_pkg::msp_item_t rd_item,
    output logic               rd_en,
    output logic               done,
    output msp_pkg::msp_out_t  result
);

    localparam int SQ = msp_pkg::SQ_STAGES;
    localparam int DV = msp_pkg::DV_STAGES;

    msp_pkg::msp_side_t s1_reg, s2_reg, s4_reg;
    msp_pkg::msp_side_t sq_reg [SQ];
    msp_pkg::msp_side_t dv_reg [DV];
    logic          s1_vld_reg, s2_vld_reg, s4_vld_reg;
    logic [SQ-1:0] sq_vld_reg;
    logic [DV-1:0] dv_vld_reg;
    logic [35:0] dx2_reg, dy2_reg;
    logic [36:0] d2_reg;
    logic [36:0] d2;
    logic [17:0] root;
    logic [17:0] d_reg;
    logic [36:0] numx_reg, numy_reg;
    logic [18:0] qx, qy;
    logic        done_reg;
    msp_pkg::msp_out_t res_reg, res_next;

    // the pipeline never stalls: pop whenever something waits
    assign rd_en = !empty;
    assign d2    = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            sq_vld_reg <= '0;
            dv_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= !empty;
            s2_vld_reg <= s1_vld_reg;
            sq_vld_reg <= {sq_vld_reg[SQ-2:0], s2_vld_reg};
            s4_vld_reg <= sq_vld_reg[SQ-1];
            dv_vld_reg <= {dv_vld_reg[DV-2:0], s4_vld_reg};
            done_reg   <= dv_vld_reg[DV-1];
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        // squares
        s1_reg.item <= rd_item;
        s1_reg.push <= 1'b0;
        s1_reg.zero <= 1'b0;
        dx2_reg     <= 36'(rd_item.adx) * 36'(rd_item.adx);
        dy2_reg     <= 36'(rd_item.ady) * 36'(rd_item.ady);
        // sum and compare with the squared minimum
        s2_reg.item <= s1_reg.item;
        s2_reg.push <= s1_reg.item.near && (d2 < {1'b0, sep2});
        s2_reg.zero <= (d2 == 37'd0);
        d2_reg      <= d2;
        // sidecar through the root
        sq_reg[0].item <= s2_reg.item;
        sq_reg[0].push <= s2_reg.push;
        sq_reg[0].zero <= s2_reg.zero;
        for (int i = 1; i < SQ; i++)
        begin
            sq_reg[i].item <= sq_reg[i-1].item;
            sq_reg[i].push <= sq_reg[i-1].push;
            sq_reg[i].zero <= sq_reg[i-1].zero;
        end
        // scale by the separation, add half the divisor for rounding
        s4_reg.item <= sq_reg[SQ-1].item;
        s4_reg.push <= sq_reg[SQ-1].push;
        s4_reg.zero <= sq_reg[SQ-1].zero;
        d_reg       <= root;
        numx_reg    <= 37'(sq_reg[SQ-1].item.adx) * 37'(sep) + 37'(root[17:1]);
        numy_reg    <= 37'(sq_reg[SQ-1].item.ady) * 37'(sep) + 37'(root[17:1]);
        // sidecar through the divider
        dv_reg[0].item <= s4_reg.item;
        dv_reg[0].push <= s4_reg.push;
        dv_reg[0].zero <= s4_reg.zero;
        for (int i = 1; i < DV; i++)
        begin
            dv_reg[i].item <= dv_reg[i-1].item;
            dv_reg[i].push <= dv_reg[i-1].push;
            dv_reg[i].zero <= dv_reg[i-1].zero;
        end
        res_reg <= res_next;
    end

    msp_isqrt u_isqrt (
        .clk  (clk),
        .rad  (d2_reg[35:0]),
        .root (root)
    );

    msp_div u_div_x (
        .clk (clk),
        .num (numx_reg),
        .den (d_reg),
        .quo (qx)
    );

    msp_div u_div_y (
        .clk (clk),
        .num (numy_reg),
        .den (d_reg),
        .quo (qy)
    );

    // final add and saturate; items that are not pushed keep the mover position
    always_comb
    begin
        logic signed [33:0] offx;
        logic signed [33:0] offy;
        msp_pkg::msp_item_t it;
        it   = dv_reg[DV-1].item;
        offx = it.sx ? -34'(qx) : 34'(qx);
        offy = it.sy ? -34'(qy) : 34'(qy);
        if (!dv_reg[DV-1].push)
        begin
            res_next.new_x  = it.mover_x;
            res_next.new_y  = it.mover_y;
            res_next.pushed = 1'b0;
        end
        else if (dv_reg[DV-1].zero)
        begin
            res_next.new_x  = msp_pkg::sat32(34'(it.anchor_x) + 34'(sep));
            res_next.new_y  = it.anchor_y;
            res_next.pushed = 1'b1;
        end
        else
        begin
            res_next.new_x  = msp_pkg::sat32(34'(it.anchor_x) + offx);
            res_next.new_y  = msp_pkg::sat32(34'(it.anchor_y) + offy);
            res_next.pushed = 1'b1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: design/min_separation_push_out.sv
// ----------------------------------------------------------------------------
// min_separation_push_out - circle overlap resolution, signed Q16.16
// Pushes a live mover out to the minimum separation around an anchor.
//
//   channel   ports                       beat
//   input     start / busy, item          mover, anchor, alive
//   result    done, result                new position, pushed flag
//   config    sep_we, sep_data            min_separation
//
// One beat per cycle in while busy is low, one result per cycle out; the result
// is registered through the queue, squares, compare, the 18 root stages, scale,
// the 19 divider stages and the output register.
// rst_n clears all valid state and loads the default separation.
// busy rises only when the two-entry queue is full; the result side
// cannot stall, so the back pipeline always moves.
// ----------------------------------------------------------------------------
module min_separation_push_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  msp_pkg::msp_in_t  item,
    input  logic              sep_we,
    input  logic [17:0]       sep_data,
    output logic              done,
    output msp_pkg::msp_out_t result
);

    localparam logic [63:0] SEP_RAW   = ((64'd3 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [17:0] SEP_RESET = (SEP_RAW > 64'h3FFFF) ? 18'h3FFFF : SEP_RAW[17:0];

    logic [17:0] sep_reg;
    logic [35:0] sep2_reg;
    logic        wr_en, rd_en, full, empty;
    msp_pkg::msp_item_t wr_item, rd_item;

    // separation register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sep_reg <= SEP_RESET;
        else if (sep_we)
            sep_reg <= sep_data;
    end

    always_ff @(posedge clk)
    begin
        sep2_reg <= 36'(sep_reg) * 36'(sep_reg);
    end

    msp_front u_front (
        .start   (start),
        .full    (full),
        .item    (item),
        .busy    (busy),
        .wr_en   (wr_en),
        .wr_item (wr_item)
    );

    msp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_item (wr_item),
        .rd_en   (rd_en),
        .full    (full),
        .empty   (empty),
        .rd_item (rd_item)
    );

    msp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .sep     (sep_reg),
        .sep2    (sep2_reg),
        .empty   (empty),
        .rd_item (rd_item),
        .rd_en   (rd_en),
        .done    (done),
        .result  (result)
    );

endmodule
